@@ design/gti_pkg.sv @@
`default_nettype none

package gti_pkg;

    localparam int COL_W       = 10;
    localparam int CFG_W       = 11;
    localparam int MODE_W      = 3;
    localparam int VERT_W      = 22;
    localparam int IDX_W       = 2;
    localparam int MAX_SIDE    = 1024;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [MODE_W-1:0] {
        DIAG_LEFT       = 3'd0,
        DIAG_RIGHT      = 3'd1,
        DIAG_RIGHT_LEFT = 3'd2,
        DIAG_LEFT_RIGHT = 3'd3,
        DIAG_CROSSED    = 3'd4
    } t_diag;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_COLS = 2'd0,
        REG_GRID_ROWS = 2'd1,
        REG_DIAG_MODE = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_LEFT,
        KIND_RIGHT,
        KIND_CROSSED,
        KIND_OOR
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0]  cols;
        logic [CFG_W-1:0]  rows;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [VERT_W-1:0] v0;
        logic [VERT_W-1:0] quad;
        logic [VERT_W-1:0] vmid;
        logic [CFG_W-1:0]  cp1;
    } t_desc;

endpackage

`default_nettype wire

@@ design/gti_front.sv @@
`default_nettype none

module gti_front #(
    parameter int DEPTH = gti_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gti_pkg::t_cfg             i_cfg,
    input  logic                      i_push,
    input  logic [gti_pkg::COL_W-1:0] i_quad_col,
    input  logic [gti_pkg::COL_W-1:0] i_quad_row,
    input  logic                      i_retire,
    output logic                      o_full,
    output logic                      o_wr_valid,
    output gti_pkg::t_desc            o_wr_desc
);
    import gti_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              accept;
    logic [CFG_W-1:0]  cols_sat, rows_sat;
    logic              oor;
    t_kind             kind;

    logic              r1_valid;
    logic [COL_W-1:0]  r1_col, r1_row;
    logic [CFG_W-1:0]  r1_cols, r1_rows;
    t_kind             r1_kind;

    logic              r2_valid;
    logic [COL_W-1:0]  r2_col, r2_row;
    logic [CFG_W-1:0]  r2_cols;
    t_kind             r2_kind;
    logic [VERT_W-1:0] r2_rc, r2_area;
    logic [VERT_W-1:0] quad;

    // occupancy covers both pipeline stages and the queue
    assign o_full = (r_occ == OCC_W'(DEPTH));
    assign accept = i_push && !o_full;
    assign n_occ  = OCC_W'(r_occ + OCC_W'(accept) - OCC_W'(i_retire));

    assign cols_sat = (i_cfg.cols > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : i_cfg.cols;
    assign rows_sat = (i_cfg.rows > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : i_cfg.rows;
    assign oor = ({1'b0, i_quad_col} >= cols_sat) || ({1'b0, i_quad_row} >= rows_sat);

    always_comb begin
        if (oor) begin
            kind = KIND_OOR;
        end else begin
            case (i_cfg.mode)
                DIAG_RIGHT:      kind = KIND_RIGHT;
                DIAG_RIGHT_LEFT: kind = (i_quad_col[0] ^ i_quad_row[0]) ? KIND_RIGHT
                                                                         : KIND_LEFT;
                DIAG_LEFT_RIGHT: kind = (i_quad_col[0] ^ i_quad_row[0]) ? KIND_LEFT
                                                                         : KIND_RIGHT;
                DIAG_CROSSED:    kind = KIND_CROSSED;
                default:         kind = KIND_LEFT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_col  <= i_quad_col;
            r1_row  <= i_quad_row;
            r1_cols <= cols_sat;
            r1_rows <= rows_sat;
            r1_kind <= kind;
        end
        r2_col  <= r1_col;
        r2_row  <= r1_row;
        r2_cols <= r1_cols;
        r2_kind <= r1_kind;
        r2_rc   <= VERT_W'(r1_row) * VERT_W'(r1_cols);
        r2_area <= (VERT_W'(r1_cols) + VERT_W'(1)) * (VERT_W'(r1_rows) + VERT_W'(1));
    end

    assign quad               = r2_rc + VERT_W'(r2_col);
    assign o_wr_valid         = r2_valid;
    assign o_wr_desc.kind     = r2_kind;
    assign o_wr_desc.quad     = quad;
    assign o_wr_desc.v0       = quad + VERT_W'(r2_row);
    assign o_wr_desc.vmid     = r2_area + quad;
    assign o_wr_desc.cp1      = r2_cols + CFG_W'(1);

endmodule

`default_nettype wire

@@ design/gti_queue.sv @@
`default_nettype none

module gti_queue #(
    parameter int DEPTH = gti_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  gti_pkg::t_desc i_wr_data,
    input  logic           i_rd,
    output logic           o_empty,
    output gti_pkg::t_desc o_rd_data
);
    import gti_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_cnt <= CNT_W'(r_cnt + CNT_W'(i_wr) - CNT_W'(i_rd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/gti_back.sv @@
`default_nettype none

module gti_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  gti_pkg::t_desc             i_desc,
    input  logic                       i_pop,
    output logic                       o_rd,
    output logic                       o_empty,
    output logic [gti_pkg::VERT_W-1:0] o_cell_number,
    output logic [gti_pkg::VERT_W-1:0] o_vert_a,
    output logic [gti_pkg::VERT_W-1:0] o_vert_b,
    output logic [gti_pkg::VERT_W-1:0] o_vert_c,
    output logic                       o_last_of_quad,
    output logic                       o_out_of_range
);
    import gti_pkg::*;

    localparam logic [1:0] CROSS_LAST = 2'd3;

    logic              r_valid;
    logic [1:0]        r_k;
    logic              load;
    logic [VERT_W-1:0] v1, v2, v3;
    logic [VERT_W-1:0] cell_no, va, vb, vc;
    logic              last, err;

    assign v1 = i_desc.v0 + VERT_W'(1);
    assign v2 = i_desc.v0 + VERT_W'(i_desc.cp1);
    assign v3 = v2 + VERT_W'(1);

    always_comb begin
        cell_no = '0;
        va      = '0;
        vb      = '0;
        vc      = '0;
        last    = 1'b0;
        err     = 1'b0;
        case (i_desc.kind)
            KIND_CROSSED: begin
                cell_no = {i_desc.quad[VERT_W-3:0], r_k};
                vc      = i_desc.vmid;
                last    = (r_k == CROSS_LAST);
                case (r_k)
                    2'd0: begin
                        va = i_desc.v0;
                        vb = v1;
                    end
                    2'd1: begin
                        va = i_desc.v0;
                        vb = v2;
                    end
                    2'd2: begin
                        va = v1;
                        vb = v3;
                    end
                    default: begin
                        va = v2;
                        vb = v3;
                    end
                endcase
            end
            KIND_LEFT: begin
                cell_no = {i_desc.quad[VERT_W-2:0], r_k[0]};
                last    = r_k[0];
                va      = r_k[0] ? v1 : i_desc.v0;
                vb      = r_k[0] ? v2 : v1;
                vc      = r_k[0] ? v3 : v2;
            end
            KIND_RIGHT: begin
                cell_no = {i_desc.quad[VERT_W-2:0], r_k[0]};
                last    = r_k[0];
                va      = i_desc.v0;
                vb      = r_k[0] ? v2 : v1;
                vc      = v3;
            end
            default: begin
                last = 1'b1;
                err  = 1'b1;
            end
        endcase
    end

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_rd    = load && last;
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= last ? 2'd0 : 2'(r_k + 2'd1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_cell_number  <= cell_no;
            o_vert_a       <= va;
            o_vert_b       <= vb;
            o_vert_c       <= vc;
            o_last_of_quad <= last;
            o_out_of_range <= err;
        end
    end

endmodule

`default_nettype wire

@@ design/grid_triangle_index_generator_core.sv @@
// Grid triangle index generator.
// Input channel: quad_col/quad_row are transferred when push is high and full
// is low. Each quad yields two triangles (left, right, alternating modes), four
// (crossed mode), or one error result when it lies outside the grid.
// Result channel: while empty is low the oldest triangle is on the o_ ports;
// it is transferred when pop is high. o_last_of_quad marks a quad's final one.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write grid_cols (0),
// grid_rows (1), diagonal_mode (2); write only while the block is idle.
// Path: a transferred quad passes both front pipeline stages and the
// descriptor queue before its first triangle is registered on the ports.
// Throughput: one triangle per cycle from the output sequencer while pop is
// high and a quad is queued. A quad enters every cycle while the pipeline and
// queue (QUEUE_DEPTH entries including the two pipeline stages) have room.
// Reset: registers return to cols 1, rows 1, left diagonal; pipeline and
// queue are emptied. When the receiver stalls, the output register holds,
// the queue fills and full rises once QUEUE_DEPTH quads are pending.
`default_nettype none

module grid_triangle_index_generator_core #(
    parameter int QUEUE_DEPTH = gti_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gti_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [gti_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [gti_pkg::COL_W-1:0]  i_quad_col,
    input  logic [gti_pkg::COL_W-1:0]  i_quad_row,
    output logic                       empty,
    input  logic                       pop,
    output logic [gti_pkg::VERT_W-1:0] o_cell_number,
    output logic [gti_pkg::VERT_W-1:0] o_vert_a,
    output logic [gti_pkg::VERT_W-1:0] o_vert_b,
    output logic [gti_pkg::VERT_W-1:0] o_vert_c,
    output logic                       o_last_of_quad,
    output logic                       o_out_of_range
);
    import gti_pkg::*;

    t_cfg  r_cfg;
    logic  wr_valid;
    t_desc wr_desc;
    logic  q_empty;
    t_desc q_desc;
    logic  q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols <= CFG_W'(1);
            r_cfg.rows <= CFG_W'(1);
            r_cfg.mode <= DIAG_LEFT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_COLS: r_cfg.cols <= i_cfg_data;
                REG_GRID_ROWS: r_cfg.rows <= i_cfg_data;
                REG_DIAG_MODE: r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                default:       r_cfg      <= r_cfg;
            endcase
        end
    end

    gti_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_quad_col (i_quad_col),
        .i_quad_row (i_quad_row),
        .i_retire   (q_rd),
        .o_full     (full),
        .o_wr_valid (wr_valid),
        .o_wr_desc  (wr_desc)
    );

    gti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_valid),
        .i_wr_data (wr_desc),
        .i_rd      (q_rd),
        .o_empty   (q_empty),
        .o_rd_data (q_desc)
    );

    gti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_desc         (q_desc),
        .i_pop          (pop),
        .o_rd           (q_rd),
        .o_empty        (empty),
        .o_cell_number  (o_cell_number),
        .o_vert_a       (o_vert_a),
        .o_vert_b       (o_vert_b),
        .o_vert_c       (o_vert_c),
        .o_last_of_quad (o_last_of_quad),
        .o_out_of_range (o_out_of_range)
    );

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("block not empty after reset");

    a_oor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_of_range |-> o_last_of_quad && o_cell_number == '0
            && o_vert_a == '0 && o_vert_b == '0 && o_vert_c == '0)
        else $error("out-of-range result malformed");

    a_vert_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_of_range |-> o_vert_a < o_vert_b && o_vert_b < o_vert_c)
        else $error("triangle vertices out of order");

    a_no_input_transfer_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !pop |=> full)
        else $error("full dropped without a result transfer");
`endif

endmodule

`default_nettype wire

@@ tb/sv/grid_triangle_index_generator_core_tb.sv @@
`default_nettype none

module grid_triangle_index_generator_core_tb;
    import gti_pkg::*;

    localparam int HALF_HIGH     = 6;
    localparam int HALF_LOW      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam int HOLD_CYCLES   = 90;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 13;
    localparam logic [MODE_W-1:0] MODE_TOP = '1;

    typedef struct packed {
        logic [VERT_W-1:0] cell_no;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] c;
        logic              last;
        logic              oor;
    } t_tri;

    class triangle_ledger;
        logic [CFG_W-1:0]  cols;
        logic [CFG_W-1:0]  rows;
        logic [MODE_W-1:0] mode;
        t_tri              due_tris[$];
        int                errors;
        int                quads;
        int                oor_quads;
        int                crossed_quads;
        int                triangles;

        function new();
            cols          = 1;
            rows          = 1;
            mode          = DIAG_LEFT;
            errors        = 0;
            quads         = 0;
            oor_quads     = 0;
            crossed_quads = 0;
            triangles     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_GRID_COLS: cols = val;
                REG_GRID_ROWS: rows = val;
                REG_DIAG_MODE: mode = val[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_tri(int unsigned cell_no, int unsigned a, int unsigned b,
                              int unsigned c, bit last, bit oor);
            t_tri t;
            t.cell_no = VERT_W'(cell_no);
            t.a       = VERT_W'(a);
            t.b       = VERT_W'(b);
            t.c       = VERT_W'(c);
            t.last    = last;
            t.oor     = oor;
            due_tris.push_back(t);
        endfunction

        // Expected triangles of one accepted quad
        function void predict_triangles(logic [COL_W-1:0] qcol, logic [COL_W-1:0] qrow);
            int unsigned cx, ry, nc, nr, v0, v1, v2, v3, q, mid;
            bit          left;
            cx = qcol;
            ry = qrow;
            nc = (cols > MAX_SIDE) ? MAX_SIDE : cols;
            nr = (rows > MAX_SIDE) ? MAX_SIDE : rows;
            quads++;
            if (cx >= nc || ry >= nr) begin
                oor_quads++;
                add_tri(0, 0, 0, 0, 1'b1, 1'b1);
                return;
            end
            v0 = ry * (nc + 1) + cx;
            v1 = v0 + 1;
            v2 = v0 + nc + 1;
            v3 = v1 + nc + 1;
            q  = ry * nc + cx;
            if (mode == DIAG_CROSSED) begin
                crossed_quads++;
                mid = (nc + 1) * (nr + 1) + q;
                add_tri(q * 4,     v0, v1, mid, 1'b0, 1'b0);
                add_tri(q * 4 + 1, v0, v2, mid, 1'b0, 1'b0);
                add_tri(q * 4 + 2, v1, v3, mid, 1'b0, 1'b0);
                add_tri(q * 4 + 3, v2, v3, mid, 1'b1, 1'b0);
                return;
            end
            case (mode)
                DIAG_RIGHT:      left = 1'b0;
                DIAG_RIGHT_LEFT: left = ((cx + ry) & 1) == 0;
                DIAG_LEFT_RIGHT: left = ((cx + ry) & 1) != 0;
                default:         left = 1'b1;
            endcase
            if (left) begin
                add_tri(q * 2,     v0, v1, v2, 1'b0, 1'b0);
                add_tri(q * 2 + 1, v1, v2, v3, 1'b1, 1'b0);
            end else begin
                add_tri(q * 2,     v0, v1, v3, 1'b0, 1'b0);
                add_tri(q * 2 + 1, v0, v2, v3, 1'b1, 1'b0);
            end
        endfunction

        function void check_tri(t_tri got);
            t_tri want;
            if (due_tris.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected triangle cell=%0d a=%0d b=%0d c=%0d",
                             got.cell_no, got.a, got.b, got.c);
                return;
            end
            want = due_tris.pop_front();
            triangles++;
            if (got.cell_no !== want.cell_no || got.a !== want.a || got.b !== want.b ||
                got.c !== want.c || got.last !== want.last || got.oor !== want.oor) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: want cell=%0d a=%0d b=%0d c=%0d last=%0b oor=%0b",
                             want.cell_no, want.a, want.b, want.c, want.last, want.oor);
                    $display("        got cell=%0d a=%0d b=%0d c=%0d last=%0b oor=%0b",
                             got.cell_no, got.a, got.b, got.c, got.last, got.oor);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_reg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                push;
    logic                full;
    logic [COL_W-1:0]    i_quad_col;
    logic [COL_W-1:0]    i_quad_row;
    logic                empty;
    logic                pop;
    logic [VERT_W-1:0]   o_cell_number;
    logic [VERT_W-1:0]   o_vert_a;
    logic [VERT_W-1:0]   o_vert_b;
    logic [VERT_W-1:0]   o_vert_c;
    logic                o_last_of_quad;
    logic                o_out_of_range;

    triangle_ledger      ledger;
    bit                  hold_req;
    bit                  tx_burst;
    bit                  rx_burst;
    int                  quiet_cycles = 0;
    int                  n_settings;

    grid_triangle_index_generator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_quad_col     (i_quad_col),
        .i_quad_row     (i_quad_row),
        .empty          (empty),
        .pop            (pop),
        .o_cell_number  (o_cell_number),
        .o_vert_a       (o_vert_a),
        .o_vert_b       (o_vert_b),
        .o_vert_c       (o_vert_c),
        .o_last_of_quad (o_last_of_quad),
        .o_out_of_range (o_out_of_range)
    );

    initial i_clk = 1'b0;
    always begin
        #HALF_LOW i_clk = 1'b1;
        #HALF_HIGH i_clk = 1'b0;
    end

    // no transfer on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_quad(input logic [COL_W-1:0] qcol, input logic [COL_W-1:0] qrow);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push       <= 1'b1;
        i_quad_col <= qcol;
        i_quad_row <= qrow;
        do @(posedge i_clk); while (full);
        ledger.predict_triangles(qcol, qrow);
    endtask

    // stop offering and wait until every expected triangle has been transferred
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (ledger.due_tris.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] gc, input logic [CFG_W-1:0] gr,
                            input logic [MODE_W-1:0] gm);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_GRID_COLS;
        i_cfg_data <= gc;
        @(negedge i_clk);
        i_cfg_idx  <= REG_GRID_ROWS;
        i_cfg_data <= gr;
        @(negedge i_clk);
        i_cfg_idx  <= REG_DIAG_MODE;
        i_cfg_data <= CFG_W'(gm);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        ledger.set_reg(REG_GRID_COLS, gc);
        ledger.set_reg(REG_GRID_ROWS, gr);
        ledger.set_reg(REG_DIAG_MODE, CFG_W'(gm));
        n_settings++;
    endtask

    function automatic logic [CFG_W-1:0] draw_side();
        case ($urandom_range(0, 4))
            0:       return CFG_W'($urandom_range(1, 3));
            1:       return CFG_W'($urandom_range(4, 40));
            2:       return CFG_W'($urandom_range(41, MAX_SIDE - 1));
            3:       return CFG_W'(MAX_SIDE);
            default: return CFG_W'($urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1));
        endcase
    endfunction

    // receiver
    initial begin
        int   gap;
        int   n_got;
        t_tri got;
        pop      = 1'b0;
        rx_burst = 1'b0;
        n_got    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.cell_no = o_cell_number;
            got.a       = o_vert_a;
            got.b       = o_vert_b;
            got.c       = o_vert_c;
            got.last    = o_last_of_quad;
            got.oor     = o_out_of_range;
            ledger.check_tri(got);
            n_got++;
            if (n_got % 25 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        int                p;
        int                k;
        int                mi;
        int                ec;
        int                er;
        logic [CFG_W-1:0]  gc;
        logic [CFG_W-1:0]  gr;
        logic [MODE_W-1:0] gm;
        logic [COL_W-1:0]  qc;
        logic [COL_W-1:0]  qr;

        ledger       = new();
        hold_req     = 1'b0;
        tx_burst     = 1'b0;
        n_settings   = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_GRID_COLS;
        i_cfg_data   = '0;
        push         = 1'b0;
        i_quad_col   = '0;
        i_quad_row   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid is one quad, left diagonal
        send_quad(0, 0);
        send_quad(1, 0);
        send_quad(0, 1);
        send_quad('1, '1);

        drain();
        set_grid(CFG_W'(MAX_SIDE), CFG_W'(MAX_SIDE), DIAG_CROSSED);
        send_quad(0, 0);
        send_quad('1, '1);
        send_quad('1, 0);
        send_quad(0, '1);

        // oversized grid saturates
        drain();
        set_grid('1, '1, DIAG_RIGHT);
        send_quad('1, '1);
        send_quad(512, 341);

        drain();
        set_grid(5, 3, DIAG_RIGHT_LEFT);
        send_quad(0, 0);
        send_quad(1, 0);
        send_quad(4, 2);
        send_quad(5, 2);

        drain();
        set_grid(5, 3, DIAG_LEFT_RIGHT);
        send_quad(0, 0);
        send_quad(3, 1);

        // undefined modes fall back to left
        for (mi = int'(DIAG_CROSSED) + 1; mi <= int'(MODE_TOP); mi++) begin
            drain();
            set_grid(5, 3, MODE_W'(mi));
            send_quad(2, 1);
        end

        // zero-sized grids
        drain();
        set_grid(0, 4, DIAG_LEFT);
        send_quad(0, 0);
        drain();
        set_grid(4, 0, DIAG_CROSSED);
        send_quad(0, 0);

        for (p = 0; p < RAND_PHASES; p++) begin
            drain();
            if (p == 0) begin
                gc = CFG_W'(MAX_SIDE);
                gr = CFG_W'(MAX_SIDE);
            end else if (p == RAND_PHASES - 1) begin
                gc = '1;
                gr = '1;
            end else begin
                gc = draw_side();
                gr = draw_side();
            end
            gm = (p < 5) ? MODE_W'(p) : MODE_W'($urandom_range(0, int'(MODE_TOP)));
            set_grid(gc, gr, gm);
            ec = (gc > MAX_SIDE) ? MAX_SIDE : gc;
            er = (gr > MAX_SIDE) ? MAX_SIDE : gr;
            tx_burst = (p == 2) || ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 6)
                    hold_req = 1'b1;
                if (p == 4 && k == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 99) < 85) begin
                    qc = COL_W'($urandom_range(0, ec - 1));
                    qr = COL_W'($urandom_range(0, er - 1));
                end else if ($urandom_range(0, 1) == 0) begin
                    qc = COL_W'($urandom_range(0, (1 << COL_W) - 1));
                    qr = COL_W'($urandom_range(0, (1 << COL_W) - 1));
                end else begin
                    // at or just past the grid edge
                    qc = COL_W'(ec - 1 + $urandom_range(0, 1));
                    qr = COL_W'(er - 1 + $urandom_range(0, 1));
                end
                send_quad(qc, qr);
            end
        end
        drain();

        $display("Run: %0d quads over %0d grid settings (%0d outside, %0d crossed),",
                 ledger.quads, n_settings, ledger.oor_quads, ledger.crossed_quads);
        $display("     %0d triangles checked, %0d errors, %0d still due",
                 ledger.triangles, ledger.errors, ledger.due_tris.size());
        if (ledger.errors == 0 && ledger.due_tris.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/gti_pkg.sv
design/gti_front.sv
design/gti_queue.sv
design/gti_back.sv
design/grid_triangle_index_generator_core.sv
tb/sv/grid_triangle_index_generator_core_tb.sv
